>>> sv/sprite_line_evaluator_defines.svh
// assertion macros for the sprite line evaluator
`ifndef SPRITE_LINE_EVALUATOR_DEFINES_SVH
`define SPRITE_LINE_EVALUATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/sle_pkg.sv
// shared types and constants for the sprite line evaluator
package sle_pkg;

  // parameter defaults
  localparam int ENTRIES_DEF = 64;
  localparam int LIMIT_DEF   = 8;

  // fixed field widths
  localparam int CNT_W   = 7;
  localparam int IDX_W   = 6;
  localparam int ROW_W   = 5;
  localparam int BYTE_W  = 8;
  localparam int LINE_W  = 9;
  localparam int CFG_IW  = 3;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_EXTENDED = 3'd0;
  localparam logic [CFG_IW-1:0] REG_TALL     = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ZOOM     = 3'd2;
  localparam logic [CFG_IW-1:0] REG_LIMIT_EN = 3'd3;
  localparam logic [CFG_IW-1:0] REG_ACTIVE_H = 3'd4;

  // table end marker and active height reset value
  localparam logic [BYTE_W-1:0] END_MARKER    = 8'd208;
  localparam logic [BYTE_W-1:0] ACTIVE_H_RST  = 8'd192;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] table_address;
    logic [BYTE_W-1:0] write_data;
    logic [LINE_W-1:0] line_number;
    logic [BYTE_W-1:0] line_counter;
  } sle_item_t;

  typedef struct packed {
    logic              has_sprite;
    logic [IDX_W-1:0]  slot;
    logic [ROW_W-1:0]  sprite_row;
    logic [BYTE_W-1:0] sprite_x;
    logic [BYTE_W-1:0] sprite_pattern;
    logic              overflow;
    logic              last;
  } sle_result_t;

  // one selected sprite, kept until the line's overflow is known
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] row;
  } sle_hit_t;

endpackage

>>> sv/sprite_line_evaluator.sv
// sprite line evaluator: attribute table memory, line scan and result emission
//
// Usage: an item is taken at a clock edge with start high and busy low.
// A write item (cmd 0) stores one table byte in that cycle and gives no
// result; busy stays low, so items may follow back to back.
// An evaluate item (cmd 1) raises busy, scans the Y bytes of entries 0 up
// to SPRITE_ENTRIES-1 one per cycle through the table memory, collects the
// selected sprites in a hit memory, then replays them through the table
// memory to fetch X and pattern. Each result is a one-cycle beat marked by
// done; the line's last beat has last set, and busy drops after it.
// An evaluate item's length is set by the single read per cycle of the Y
// scan and of the hit replay. An empty line gives one beat.
// The receiver cannot stall: beats come one per cycle, back to back.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
// and are meant for idle time.
// Reset: synchronous; afterwards the block clears the 256-byte table, one
// byte a cycle, holding busy high until the clear is done.
`include "sprite_line_evaluator_defines.svh"

module sprite_line_evaluator #(
  parameter int SPRITE_ENTRIES    = sle_pkg::ENTRIES_DEF,
  parameter int LINE_SPRITE_LIMIT = sle_pkg::LIMIT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  sle_pkg::sle_item_t         item,
  output logic                       busy,
  output logic                       done,
  output sle_pkg::sle_result_t       result,
  input  logic                       cfg_we,
  input  logic [sle_pkg::CFG_IW-1:0] cfg_index,
  input  logic [sle_pkg::BYTE_W-1:0] cfg_data
);
  import sle_pkg::*;

  localparam int HIT_AW = (SPRITE_ENTRIES > 1) ? $clog2(SPRITE_ENTRIES) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  // configuration registers
  logic              extended_mode;
  logic              tall_sprites;
  logic              zoomed_sprites;
  logic              sprite_limit_enable;
  logic [BYTE_W-1:0] active_height;

  // control
  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [BYTE_W-1:0] clr;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  ei;
  logic              ovf;
  logic              p_valid;
  logic              a_valid;
  logic              b_valid;
  logic              c_valid;

  // payload
  logic [IDX_W-1:0]  p_idx;
  logic [BYTE_W-1:0] lc;
  logic [LINE_W-1:0] ln;
  logic [CNT_W-1:0]  a_slot;
  logic [CNT_W-1:0]  b_slot;
  logic [ROW_W-1:0]  b_row;
  logic              b_last;
  logic              c_has;
  logic [IDX_W-1:0]  c_slot;
  logic [ROW_W-1:0]  c_row;
  logic              c_last;
  logic [BYTE_W-1:0] c_x;
  logic [BYTE_W-1:0] c_pat;

  // memories
  logic [BYTE_W-1:0] tab_mem [0:255];
  logic [BYTE_W-1:0] tab_rd_a;
  logic [BYTE_W-1:0] tab_rd_b;
  sle_hit_t          hit_mem [0:SPRITE_ENTRIES-1];
  sle_hit_t          hit_rd;

  logic              accept;
  logic              tab_we;
  logic [BYTE_W-1:0] tab_waddr;
  logic [BYTE_W-1:0] tab_wdata;
  logic [BYTE_W-1:0] tab_addr_a;
  logic [BYTE_W-1:0] tab_addr_b;
  logic [5:0]        height;
  logic [BYTE_W-1:0] row;
  logic              end_mark;
  logic              hit;
  logic              at_limit;
  logic              store;
  logic              stop;
  logic              issue;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // sprite height from size bits
  always_comb begin
    case ({tall_sprites, zoomed_sprites})
      2'b00:   height = 6'd8;
      2'b01:   height = 6'd16;
      2'b10:   height = 6'd16;
      default: height = 6'd32;
    endcase
  end

  // scan test on the Y byte read last cycle
  assign row      = lc - tab_rd_a;
  assign end_mark = !extended_mode && (tab_rd_a == END_MARKER);
  assign hit      = p_valid && !end_mark && (row < {2'b00, height});
  assign at_limit = hit && (32'(count) == LINE_SPRITE_LIMIT);
  assign store    = hit && !(at_limit && sprite_limit_enable);
  assign stop     = p_valid && (end_mark || (at_limit && sprite_limit_enable) ||
                    (32'(p_idx) == SPRITE_ENTRIES - 1));
  assign issue    = (state == ST_SCAN) && !stop && (rd_idx < CNT_W'(SPRITE_ENTRIES));

  // table write port: clearing pass or a write beat
  assign tab_we    = (state == ST_CLEAR) || (accept && item.cmd == CMD_WRITE);
  assign tab_waddr = (state == ST_CLEAR) ? clr : item.table_address;
  assign tab_wdata = (state == ST_CLEAR) ? '0 : item.write_data;

  // table read ports: Y during scan, X and pattern during replay
  assign tab_addr_a = (state == ST_SCAN) ? {2'b00, rd_idx[IDX_W-1:0]}
                                         : {1'b1, hit_rd.idx, 1'b0};
  assign tab_addr_b = {1'b1, hit_rd.idx, 1'b1};

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    tab_rd_a <= tab_mem[tab_addr_a];
    tab_rd_b <= tab_mem[tab_addr_b];
  end

  // hit memory: written in scan order, replayed after the scan
  always_ff @(posedge clk) begin
    if (store) begin
      hit_mem[count[HIT_AW-1:0]] <= '{idx: p_idx, row: row[ROW_W-1:0]};
    end
    hit_rd <= hit_mem[ei[HIT_AW-1:0]];
  end

  // state sequencing
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr == '1) state_next = ST_IDLE;
      ST_IDLE:  if (accept && item.cmd == CMD_EVAL) state_next = ST_SCAN;
      ST_SCAN:  if (stop) state_next = ST_EMIT;
      ST_EMIT:  if (count == '0 || ei == count - CNT_W'(1)) state_next = ST_DRAIN;
      ST_DRAIN: if (c_valid && c_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_CLEAR;
      clr                 <= '0;
      rd_idx              <= '0;
      count               <= '0;
      ei                  <= '0;
      ovf                 <= 1'b0;
      p_valid             <= 1'b0;
      a_valid             <= 1'b0;
      b_valid             <= 1'b0;
      c_valid             <= 1'b0;
      extended_mode       <= 1'b0;
      tall_sprites        <= 1'b0;
      zoomed_sprites      <= 1'b0;
      sprite_limit_enable <= 1'b1;
      active_height       <= ACTIVE_H_RST;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr <= clr + BYTE_W'(1);
      end
      // start of a line
      if (accept && item.cmd == CMD_EVAL) begin
        rd_idx <= '0;
        count  <= '0;
        ovf    <= 1'b0;
      end
      // scan: one Y read issued, one tested per cycle
      p_valid <= issue;
      if (issue) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      if (store) begin
        count <= count + CNT_W'(1);
      end
      if (at_limit && ({1'b0, active_height} > ln)) begin
        ovf <= 1'b1;
      end
      if (stop) begin
        ei <= '0;
      end
      // replay: hit read, then X and pattern read
      a_valid <= (state == ST_EMIT) && (count != '0);
      if ((state == ST_EMIT) && (count != '0)) begin
        ei <= ei + CNT_W'(1);
      end
      b_valid <= a_valid;
      c_valid <= b_valid || ((state == ST_EMIT) && (count == '0));
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_EXTENDED: extended_mode       <= cfg_data[0];
          REG_TALL:     tall_sprites        <= cfg_data[0];
          REG_ZOOM:     zoomed_sprites      <= cfg_data[0];
          REG_LIMIT_EN: sprite_limit_enable <= cfg_data[0];
          REG_ACTIVE_H: active_height       <= cfg_data;
          default:      ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      lc <= item.line_counter;
      ln <= item.line_number;
    end
    if (issue) begin
      p_idx <= rd_idx[IDX_W-1:0];
    end
    a_slot <= ei;
    b_slot <= a_slot;
    b_row  <= hit_rd.row;
    b_last <= (a_slot == count - CNT_W'(1));
    c_has  <= b_valid;
    c_slot <= b_valid ? b_slot[IDX_W-1:0] : '0;
    c_row  <= b_valid ? b_row : '0;
    c_last <= b_valid ? b_last : 1'b1;
    // table bytes arrive in the same cycle as the rest of stage b
    c_x    <= b_valid ? tab_rd_a : '0;
    c_pat  <= b_valid ? tab_rd_b : '0;
  end

  // result beat
  assign done                  = c_valid;
  assign result.has_sprite     = c_has;
  assign result.slot           = c_slot;
  assign result.sprite_row     = c_row;
  assign result.sprite_x       = c_x;
  assign result.sprite_pattern = c_pat;
  assign result.overflow       = c_has && ovf;
  assign result.last           = c_last;

  // checks
  `SLE_ASSERT_NOW(a_done_busy, done, busy, "result beat while idle")
  `SLE_ASSERT_NEXT(a_last_ends, done && result.last, !done, "beat after last beat")
  `SLE_ASSERT_NOW(a_empty_last, done && !result.has_sprite, result.last, "empty beat not last")
  `SLE_ASSERT_NEXT(a_write_idle, accept && item.cmd == CMD_WRITE, !busy && !done,
    "write beat left block busy")
  `SLE_ASSERT_NEXT(a_eval_busy, accept && item.cmd == CMD_EVAL, busy && !done,
    "evaluate beat did not start a scan")

endmodule

>>> tb/tb.sv
// self-checking testbench for the sprite line evaluator
module tb;
  import sle_pkg::*;

  localparam logic [BYTE_W-1:0] XPAT_BASE = 8'h80;
  localparam logic [CFG_IW-1:0] REG_UNUSED_LO = REG_ACTIVE_H + 3'd1;
  localparam logic [CFG_IW-1:0] REG_UNUSED_HI = {CFG_IW{1'b1}};
  localparam int LAST_LINE = 312;
  localparam int CYCLE_LIMIT = 200000;

  // predicted line results and running check of the result beats
  class sprite_scoreboard;
    logic [BYTE_W-1:0] attr_table [256];
    bit ext_mode, tall, zoom, limit_en;
    logic [BYTE_W-1:0] active_h;
    sle_result_t line_results[$];
    int unsigned errors, lines, sprite_beats, ovf_lines, widest_line;

    function new();
      foreach (attr_table[a]) attr_table[a] = '0;
      ext_mode = 1'b0;
      tall = 1'b0;
      zoom = 1'b0;
      limit_en = 1'b1;
      active_h = ACTIVE_H_RST;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [BYTE_W-1:0] val);
      case (idx)
        REG_EXTENDED: ext_mode = val[0];
        REG_TALL:     tall = val[0];
        REG_ZOOM:     zoom = val[0];
        REG_LIMIT_EN: limit_en = val[0];
        REG_ACTIVE_H: active_h = val;
        default: ;
      endcase
    endfunction

    // table write, or scan of one line into expected beats
    function void note_item(sle_item_t it);
      int unsigned height;
      int unsigned count;
      bit ovf;
      logic [BYTE_W-1:0] y, row, xa;
      sle_result_t r;
      sle_result_t found[$];
      if (it.cmd == CMD_WRITE) begin
        attr_table[it.table_address] = it.write_data;
        return;
      end
      height = 8;
      if (tall) height = height * 2;
      if (zoom) height = height * 2;
      count = 0;
      ovf = 1'b0;
      for (int i = 0; i < ENTRIES_DEF; i++) begin
        y = attr_table[i];
        if (!ext_mode && y == END_MARKER) break;
        row = it.line_counter - y;
        if (row < height) begin
          if (count == LIMIT_DEF) begin
            if (it.line_number < {1'b0, active_h}) ovf = 1'b1;
            if (limit_en) break;
          end
          xa = XPAT_BASE + 8'(2 * i);
          r = '0;
          r.has_sprite = 1'b1;
          r.slot = IDX_W'(count);
          r.sprite_row = row[ROW_W-1:0];
          r.sprite_x = attr_table[xa];
          r.sprite_pattern = attr_table[8'(xa + 8'd1)];
          found.push_back(r);
          count++;
        end
      end
      lines++;
      if (ovf) ovf_lines++;
      if (count > widest_line) widest_line = count;
      // empty line still gives one beat
      if (found.size() == 0) begin
        r = '0;
        r.last = 1'b1;
        line_results.push_back(r);
        return;
      end
      foreach (found[k]) begin
        found[k].overflow = ovf;
        found[k].last = (k == found.size() - 1);
        line_results.push_back(found[k]);
      end
    endfunction

    function void diff(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(sle_result_t got);
      sle_result_t want;
      if (line_results.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
        return;
      end
      want = line_results.pop_front();
      if (got.has_sprite) sprite_beats++;
      diff("has_sprite", want.has_sprite, got.has_sprite);
      diff("slot", want.slot, got.slot);
      diff("sprite_row", want.sprite_row, got.sprite_row);
      diff("sprite_x", want.sprite_x, got.sprite_x);
      diff("sprite_pattern", want.sprite_pattern, got.sprite_pattern);
      diff("overflow", want.overflow, got.overflow);
      diff("last", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  sle_item_t cmd_item = '0;
  logic busy, done;
  sle_result_t res;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [BYTE_W-1:0] cfg_data = '0;

  sprite_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned n_items = 0;
  bit no_idle = 1'b0;

  sprite_line_evaluator dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(cmd_item),
    .busy(busy),
    .done(done),
    .result(res),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // result beats are checked as they go by
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(res);
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one command beat, held until start meets a low busy
  task automatic send(sle_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd_item <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    n_items++;
  endtask

  function automatic sle_item_t noise_item();
    sle_item_t it;
    it.cmd = 1'($urandom);
    it.table_address = 8'($urandom);
    it.write_data = 8'($urandom);
    it.line_number = LINE_W'($urandom_range(0, LAST_LINE));
    it.line_counter = 8'($urandom);
    return it;
  endfunction

  task automatic put_byte(logic [BYTE_W-1:0] addr, logic [BYTE_W-1:0] data);
    sle_item_t it;
    it = noise_item();
    it.cmd = CMD_WRITE;
    it.table_address = addr;
    it.write_data = data;
    send(it);
  endtask

  task automatic eval_line(logic [BYTE_W-1:0] lc, int unsigned ln);
    sle_item_t it;
    it = noise_item();
    it.cmd = CMD_EVAL;
    it.line_counter = lc;
    it.line_number = LINE_W'(ln);
    send(it);
  endtask

  // sender holds off until every expected beat is in and busy is low
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.line_results.size() != 0 || busy);
  endtask

  // idle point between phases: writes give no beat, so allow some slack
  task automatic settle();
    drain();
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // all five registers plus one unused index, back to back
  task automatic program_regs(bit ext, bit tl, bit zm, bit lim, logic [BYTE_W-1:0] ah);
    logic [CFG_IW-1:0] idx [6];
    logic [BYTE_W-1:0] val [6];
    idx = '{REG_EXTENDED, REG_TALL, REG_ZOOM, REG_LIMIT_EN, REG_ACTIVE_H,
            CFG_IW'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI))};
    val = '{{7'($urandom), ext}, {7'($urandom), tl}, {7'($urandom), zm},
            {7'($urandom), lim}, ah, 8'($urandom)};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // table updates clustered around one vertical position, mixed with line scans near it
  task automatic random_phase(int unsigned n);
    logic [BYTE_W-1:0] focus;
    sle_item_t it;
    int unsigned kind;
    case ($urandom_range(0, 3))
      0: focus = 8'd0;
      1: focus = END_MARKER - 8'd4;
      2: focus = 8'd248;
      default: focus = 8'($urandom);
    endcase
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      it = noise_item();
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        it.cmd = CMD_WRITE;
        it.table_address = 8'($urandom_range(0, ENTRIES_DEF - 1));
        it.write_data = ($urandom_range(0, 9) == 0) ? END_MARKER
                                                     : 8'(focus + $urandom_range(0, 15));
      end else if (kind < 60) begin
        it.cmd = CMD_WRITE;
        it.table_address = XPAT_BASE + 8'($urandom_range(0, 127));
      end else if (kind < 65) begin
        it.cmd = CMD_WRITE;
      end else begin
        it.cmd = CMD_EVAL;
        if (kind < 95) it.line_counter = 8'(focus + $urandom_range(0, 31));
        if ($urandom_range(0, 1)) begin
          it.line_number = {1'b0, sb.active_h};
          if ($urandom_range(0, 1) && sb.active_h != 0) begin
            it.line_number = it.line_number - LINE_W'(1);
          end
        end
      end
      send(it);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // table clear after reset keeps busy high
    do @(posedge clk); while (busy);

    // directed: reset settings
    eval_line(8'd0, 0);
    eval_line(8'd0, 200);
    eval_line(8'd100, 50);
    put_byte(XPAT_BASE, 8'hFF);
    put_byte(XPAT_BASE + 8'd1, 8'hFF);
    put_byte(8'd0, 8'd250);
    put_byte(8'd2, END_MARKER);
    eval_line(8'd1, 191);
    put_byte(8'd64, 8'hFF);
    put_byte(8'hFF, 8'hAA);
    put_byte(8'd63, 8'hFF);
    eval_line(8'hFF, LAST_LINE);

    // directed: extended, tall, zoomed, no limit
    settle();
    program_regs(1'b1, 1'b1, 1'b1, 1'b0, 8'hFF);
    eval_line(8'd0, 10);
    eval_line(8'd215, LAST_LINE);
    eval_line(8'd0, 255);

    // directed: tall only, overflow window closed
    settle();
    program_regs(1'b0, 1'b1, 1'b0, 1'b1, 8'd0);
    eval_line(8'd15, 0);
    put_byte(8'd2, 8'd0);
    eval_line(8'd15, 0);

    // directed: zoom only
    settle();
    program_regs(1'b0, 1'b0, 1'b1, 1'b1, ACTIVE_H_RST);
    eval_line(8'd15, 100);
    eval_line(8'hFF, 0);

    // random phases over several settings
    settle();
    program_regs(1'b0, 1'b0, 1'b0, 1'b1, ACTIVE_H_RST);
    no_idle = 1'b0;
    random_phase(30);
    settle();
    program_regs(1'b1, 1'b0, 1'b1, 1'b1, 8'd0);
    no_idle = 1'b1;
    random_phase(30);
    settle();
    program_regs(1'b0, 1'b1, 1'b0, 1'b0, 8'd128);
    no_idle = ($urandom_range(0, 3) == 0);
    random_phase(30);
    settle();
    program_regs(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
    no_idle = ($urandom_range(0, 3) == 0);
    random_phase(30);
    settle();
    program_regs(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
    no_idle = 1'b0;
    random_phase(30);

    // wind down, then allow a full scan's worth of cycles for strays
    drain();
    repeat (2 * ENTRIES_DEF + 8) @(posedge clk);
    $display("covered %0d items: %0d line scans, %0d sprite beats, %0d lines with overflow",
             n_items, sb.lines, sb.sprite_beats, sb.ovf_lines);
    $display("most sprites on one line: %0d, over %0d cycles", sb.widest_line, cycles);
    if (sb.errors == 0 && sb.line_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
